@@ design/clpm_pkg.sv @@
// Package for the cluster pair merge test.
// Holds the word types of both channels, the divider lane type, widths and register codes.
// No dependencies.
package clpm_pkg;

    localparam int CW   = 30;   // scaled coordinate, Q.16 cm
    localparam int DW   = 31;   // coordinate difference, signed
    localparam int PRW  = 62;   // signed product of two differences
    localparam int SQW  = 61;   // square of a difference
    localparam int LW   = 62;   // sum of two squares, Q.32
    localparam int DOTW = 63;   // dot product, signed
    localparam int TW   = 16;   // projection, Q0.16
    localparam int PW   = 48;   // projection times difference, signed
    localparam int EW   = 32;   // offset to the closest point, signed
    localparam int QW   = 46;   // distance truncated to Q.16
    localparam int AW   = 41;   // scaled slope, signed
    localparam int AGW  = 43;   // slope difference, signed
    localparam int NLANE = 4;

    localparam logic signed [AGW-1:0] HALF_TURN = 43'sd3019898880;

    localparam logic [2:0] REG_WIRE_SCALE     = 3'd0;
    localparam logic [2:0] REG_TIME_SCALE     = 3'd1;
    localparam logic [2:0] REG_SLOPE_SCALE    = 3'd2;
    localparam logic [2:0] REG_MIN_LEN_SQ     = 3'd3;
    localparam logic [2:0] REG_MAX_ANGLE_DIFF = 3'd4;
    localparam logic [2:0] REG_MAX_DIST_SQ    = 3'd5;

    typedef struct packed {
        logic [12:0]        a_start_wire;
        logic [13:0]        a_start_tick;
        logic [12:0]        a_end_wire;
        logic [13:0]        a_end_tick;
        logic signed [15:0] a_slope;
        logic [12:0]        b_start_wire;
        logic [13:0]        b_start_tick;
        logic [12:0]        b_end_wire;
        logic [13:0]        b_end_tick;
        logic signed [15:0] b_slope;
    } t_in_word;

    typedef struct packed {
        logic        merge_ok;
        logic        angle_ok;
        logic        distance_ok;
        logic [47:0] min_dist_sq;
        logic        short_segment;
    } t_out_word;

    typedef struct packed {
        logic [LW-1:0]        rem;
        logic [LW-1:0]        len2;
        logic [TW-1:0]        t;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [DW-1:0] qx;
        logic signed [DW-1:0] qy;
        logic [LW-1:0]        dfix;
        logic                 mid;
    } t_dlane;

    typedef struct packed {
        logic ang;
        logic shrt;
    } t_side;

endpackage

@@ design/clpm_if.sv @@
// Valid/ready channel interfaces for the cluster pair merge test.
// Depends on clpm_pkg for the word types.
interface clpm_in_if;
    logic                valid;
    logic                ready;
    clpm_pkg::t_in_word  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface clpm_out_if;
    logic                valid;
    logic                ready;
    clpm_pkg::t_out_word data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

@@ design/cluster_pair_merge_test.sv @@
// Cluster pair merge test: angle cut and minimum endpoint-to-segment distance.
// Depends on clpm_pkg and the channel interfaces in clpm_if.
// There are 28 register stages.
// One word is accepted per cycle while the output is taken.
// The 16 stage restoring divider for the projection sets the depth; all stages stall together.
// Reset is synchronous and active low; it empties the pipeline and loads register defaults.
module cluster_pair_merge_test (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    clpm_in_if.sink              i_pair,
    clpm_out_if.source           o_res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [5:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    localparam int NST = 28;
    localparam int NDIV = clpm_pkg::TW;
    localparam int NSD = NDIV + 7;

    logic [15:0] r_wire_scale;
    logic [15:0] r_time_scale;
    logic [23:0] r_slope_scale;
    logic [31:0] r_min_len_sq;
    logic [15:0] r_max_angle_diff;
    logic [47:0] r_max_dist_sq;

    logic           en;
    logic [NST-1:0] r_v;

    assign pready = 1'b1;
    assign en = !r_v[NST-1] || o_res.ready;
    assign i_pair.ready = en;
    assign o_res.valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wire_scale     <= 16'd19661;
            r_time_scale     <= 16'd3604;
            r_slope_scale    <= 24'd12015;
            r_min_len_sq     <= 32'd198;
            r_max_angle_diff <= 16'd46080;
            r_max_dist_sq    <= 48'hFFFF_FFFF_FFFF;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[5:3])
                clpm_pkg::REG_WIRE_SCALE:     r_wire_scale     <= pwdata[15:0];
                clpm_pkg::REG_TIME_SCALE:     r_time_scale     <= pwdata[15:0];
                clpm_pkg::REG_SLOPE_SCALE:    r_slope_scale    <= pwdata[23:0];
                clpm_pkg::REG_MIN_LEN_SQ:     r_min_len_sq     <= pwdata[31:0];
                clpm_pkg::REG_MAX_ANGLE_DIFF: r_max_angle_diff <= pwdata[15:0];
                clpm_pkg::REG_MAX_DIST_SQ:    r_max_dist_sq    <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            clpm_pkg::REG_WIRE_SCALE:     prdata = {48'd0, r_wire_scale};
            clpm_pkg::REG_TIME_SCALE:     prdata = {48'd0, r_time_scale};
            clpm_pkg::REG_SLOPE_SCALE:    prdata = {40'd0, r_slope_scale};
            clpm_pkg::REG_MIN_LEN_SQ:     prdata = {32'd0, r_min_len_sq};
            clpm_pkg::REG_MAX_ANGLE_DIFF: prdata = {48'd0, r_max_angle_diff};
            clpm_pkg::REG_MAX_DIST_SQ:    prdata = {16'd0, r_max_dist_sq};
            default:                      prdata = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NST-2:0], i_pair.valid};
        end
    end

    function automatic logic [clpm_pkg::AGW-1:0] abs_ag(input logic signed [clpm_pkg::AGW-1:0] v);
        return v < 0 ? $unsigned(-v) : $unsigned(v);
    endfunction

    function automatic clpm_pkg::t_dlane div_step(input clpm_pkg::t_dlane a);
        clpm_pkg::t_dlane      b;
        logic [clpm_pkg::LW:0] sh;
        b  = a;
        sh = {a.rem, 1'b0};
        if (sh >= {1'b0, a.len2}) begin
            b.rem = clpm_pkg::LW'(sh - {1'b0, a.len2});
            b.t   = {a.t[clpm_pkg::TW-2:0], 1'b1};
        end else begin
            b.rem = sh[clpm_pkg::LW-1:0];
            b.t   = {a.t[clpm_pkg::TW-2:0], 1'b0};
        end
        return b;
    endfunction

    // Stage 1: scale coordinates and slopes.
    logic [clpm_pkg::CW-1:0]        r1_asw, r1_ast, r1_aew, r1_aet;
    logic [clpm_pkg::CW-1:0]        r1_bsw, r1_bst, r1_bew, r1_bet;
    logic signed [clpm_pkg::AW-1:0] r1_a1, r1_a2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_asw <= clpm_pkg::CW'(i_pair.data.a_start_wire) * clpm_pkg::CW'(r_wire_scale);
            r1_ast <= clpm_pkg::CW'(i_pair.data.a_start_tick) * clpm_pkg::CW'(r_time_scale);
            r1_aew <= clpm_pkg::CW'(i_pair.data.a_end_wire) * clpm_pkg::CW'(r_wire_scale);
            r1_aet <= clpm_pkg::CW'(i_pair.data.a_end_tick) * clpm_pkg::CW'(r_time_scale);
            r1_bsw <= clpm_pkg::CW'(i_pair.data.b_start_wire) * clpm_pkg::CW'(r_wire_scale);
            r1_bst <= clpm_pkg::CW'(i_pair.data.b_start_tick) * clpm_pkg::CW'(r_time_scale);
            r1_bew <= clpm_pkg::CW'(i_pair.data.b_end_wire) * clpm_pkg::CW'(r_wire_scale);
            r1_bet <= clpm_pkg::CW'(i_pair.data.b_end_tick) * clpm_pkg::CW'(r_time_scale);
            r1_a1  <= clpm_pkg::AW'(i_pair.data.a_slope)
                      * clpm_pkg::AW'($signed({1'b0, r_slope_scale}));
            r1_a2  <= clpm_pkg::AW'(i_pair.data.b_slope)
                      * clpm_pkg::AW'($signed({1'b0, r_slope_scale}));
        end
    end

    // Stage 2: differences for each lane (point to segment) and the slope difference.
    logic [clpm_pkg::CW-1:0] n_px [clpm_pkg::NLANE];
    logic [clpm_pkg::CW-1:0] n_py [clpm_pkg::NLANE];
    logic [clpm_pkg::CW-1:0] n_sx [clpm_pkg::NLANE];
    logic [clpm_pkg::CW-1:0] n_sy [clpm_pkg::NLANE];
    logic [clpm_pkg::CW-1:0] n_ex [clpm_pkg::NLANE];
    logic [clpm_pkg::CW-1:0] n_ey [clpm_pkg::NLANE];

    always_comb begin
        n_px[0] = r1_asw; n_py[0] = r1_ast;
        n_px[1] = r1_aew; n_py[1] = r1_aet;
        n_px[2] = r1_bsw; n_py[2] = r1_bst;
        n_px[3] = r1_bew; n_py[3] = r1_bet;
        for (int l = 0; l < 2; l++) begin
            n_sx[l] = r1_bsw; n_sy[l] = r1_bst;
            n_ex[l] = r1_bew; n_ey[l] = r1_bet;
            n_sx[l+2] = r1_asw; n_sy[l+2] = r1_ast;
            n_ex[l+2] = r1_aew; n_ey[l+2] = r1_aet;
        end
    end

    logic signed [clpm_pkg::DW-1:0]  r2_dx [clpm_pkg::NLANE];
    logic signed [clpm_pkg::DW-1:0]  r2_dy [clpm_pkg::NLANE];
    logic signed [clpm_pkg::DW-1:0]  r2_qx [clpm_pkg::NLANE];
    logic signed [clpm_pkg::DW-1:0]  r2_qy [clpm_pkg::NLANE];
    logic signed [clpm_pkg::DW-1:0]  r2_rx [clpm_pkg::NLANE];
    logic signed [clpm_pkg::DW-1:0]  r2_ry [clpm_pkg::NLANE];
    logic signed [clpm_pkg::AGW-1:0] r2_d;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < clpm_pkg::NLANE; l++) begin
                r2_dx[l] <= $signed({1'b0, n_ex[l]}) - $signed({1'b0, n_sx[l]});
                r2_dy[l] <= $signed({1'b0, n_ey[l]}) - $signed({1'b0, n_sy[l]});
                r2_qx[l] <= $signed({1'b0, n_px[l]}) - $signed({1'b0, n_sx[l]});
                r2_qy[l] <= $signed({1'b0, n_py[l]}) - $signed({1'b0, n_sy[l]});
                r2_rx[l] <= $signed({1'b0, n_px[l]}) - $signed({1'b0, n_ex[l]});
                r2_ry[l] <= $signed({1'b0, n_py[l]}) - $signed({1'b0, n_ey[l]});
            end
            r2_d <= clpm_pkg::AGW'(r1_a1) - clpm_pkg::AGW'(r1_a2);
        end
    end

    // Stage 3: products.
    logic [clpm_pkg::SQW-1:0]         r3_dx2 [clpm_pkg::NLANE];
    logic [clpm_pkg::SQW-1:0]         r3_dy2 [clpm_pkg::NLANE];
    logic [clpm_pkg::SQW-1:0]         r3_qx2 [clpm_pkg::NLANE];
    logic [clpm_pkg::SQW-1:0]         r3_qy2 [clpm_pkg::NLANE];
    logic [clpm_pkg::SQW-1:0]         r3_rx2 [clpm_pkg::NLANE];
    logic [clpm_pkg::SQW-1:0]         r3_ry2 [clpm_pkg::NLANE];
    logic signed [clpm_pkg::PRW-1:0]  r3_pxd [clpm_pkg::NLANE];
    logic signed [clpm_pkg::PRW-1:0]  r3_pyd [clpm_pkg::NLANE];
    logic signed [clpm_pkg::DW-1:0]   r3_dx  [clpm_pkg::NLANE];
    logic signed [clpm_pkg::DW-1:0]   r3_dy  [clpm_pkg::NLANE];
    logic signed [clpm_pkg::DW-1:0]   r3_qx  [clpm_pkg::NLANE];
    logic signed [clpm_pkg::DW-1:0]   r3_qy  [clpm_pkg::NLANE];
    logic signed [clpm_pkg::AGW-1:0]  r3_d, r3_dm, r3_dp;
    logic signed [clpm_pkg::PRW-1:0]  n3_dx2 [clpm_pkg::NLANE];
    logic signed [clpm_pkg::PRW-1:0]  n3_dy2 [clpm_pkg::NLANE];
    logic signed [clpm_pkg::PRW-1:0]  n3_qx2 [clpm_pkg::NLANE];
    logic signed [clpm_pkg::PRW-1:0]  n3_qy2 [clpm_pkg::NLANE];
    logic signed [clpm_pkg::PRW-1:0]  n3_rx2 [clpm_pkg::NLANE];
    logic signed [clpm_pkg::PRW-1:0]  n3_ry2 [clpm_pkg::NLANE];

    always_comb begin
        for (int l = 0; l < clpm_pkg::NLANE; l++) begin
            n3_dx2[l] = clpm_pkg::PRW'(r2_dx[l]) * clpm_pkg::PRW'(r2_dx[l]);
            n3_dy2[l] = clpm_pkg::PRW'(r2_dy[l]) * clpm_pkg::PRW'(r2_dy[l]);
            n3_qx2[l] = clpm_pkg::PRW'(r2_qx[l]) * clpm_pkg::PRW'(r2_qx[l]);
            n3_qy2[l] = clpm_pkg::PRW'(r2_qy[l]) * clpm_pkg::PRW'(r2_qy[l]);
            n3_rx2[l] = clpm_pkg::PRW'(r2_rx[l]) * clpm_pkg::PRW'(r2_rx[l]);
            n3_ry2[l] = clpm_pkg::PRW'(r2_ry[l]) * clpm_pkg::PRW'(r2_ry[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < clpm_pkg::NLANE; l++) begin
                r3_dx2[l] <= n3_dx2[l][clpm_pkg::SQW-1:0];
                r3_dy2[l] <= n3_dy2[l][clpm_pkg::SQW-1:0];
                r3_qx2[l] <= n3_qx2[l][clpm_pkg::SQW-1:0];
                r3_qy2[l] <= n3_qy2[l][clpm_pkg::SQW-1:0];
                r3_rx2[l] <= n3_rx2[l][clpm_pkg::SQW-1:0];
                r3_ry2[l] <= n3_ry2[l][clpm_pkg::SQW-1:0];
                r3_pxd[l] <= clpm_pkg::PRW'(r2_qx[l]) * clpm_pkg::PRW'(r2_dx[l]);
                r3_pyd[l] <= clpm_pkg::PRW'(r2_qy[l]) * clpm_pkg::PRW'(r2_dy[l]);
                r3_dx[l]  <= r2_dx[l];
                r3_dy[l]  <= r2_dy[l];
                r3_qx[l]  <= r2_qx[l];
                r3_qy[l]  <= r2_qy[l];
            end
            r3_d  <= r2_d;
            r3_dm <= r2_d - clpm_pkg::HALF_TURN;
            r3_dp <= r2_d + clpm_pkg::HALF_TURN;
        end
    end

    // Stage 4: sums and the angle cut.
    logic [clpm_pkg::LW-1:0]          r4_len2 [clpm_pkg::NLANE];
    logic signed [clpm_pkg::DOTW-1:0] r4_dot  [clpm_pkg::NLANE];
    logic [clpm_pkg::LW-1:0]          r4_ds   [clpm_pkg::NLANE];
    logic [clpm_pkg::LW-1:0]          r4_de   [clpm_pkg::NLANE];
    logic signed [clpm_pkg::DW-1:0]   r4_dx   [clpm_pkg::NLANE];
    logic signed [clpm_pkg::DW-1:0]   r4_dy   [clpm_pkg::NLANE];
    logic signed [clpm_pkg::DW-1:0]   r4_qx   [clpm_pkg::NLANE];
    logic signed [clpm_pkg::DW-1:0]   r4_qy   [clpm_pkg::NLANE];
    logic                             r4_ang;
    logic [clpm_pkg::AGW-1:0]         n4_cut;

    assign n4_cut = {11'd0, r_max_angle_diff, 16'd0};

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < clpm_pkg::NLANE; l++) begin
                r4_len2[l] <= clpm_pkg::LW'(r3_dx2[l]) + clpm_pkg::LW'(r3_dy2[l]);
                r4_dot[l]  <= clpm_pkg::DOTW'(r3_pxd[l]) + clpm_pkg::DOTW'(r3_pyd[l]);
                r4_ds[l]   <= clpm_pkg::LW'(r3_qx2[l]) + clpm_pkg::LW'(r3_qy2[l]);
                r4_de[l]   <= clpm_pkg::LW'(r3_rx2[l]) + clpm_pkg::LW'(r3_ry2[l]);
                r4_dx[l]   <= r3_dx[l];
                r4_dy[l]   <= r3_dy[l];
                r4_qx[l]   <= r3_qx[l];
                r4_qy[l]   <= r3_qy[l];
            end
            r4_ang <= (abs_ag(r3_d) < n4_cut) || (abs_ag(r3_dm) < n4_cut)
                      || (abs_ag(r3_dp) < n4_cut);
        end
    end

    // Stage 5: short segment and projection range; then the divider.
    clpm_pkg::t_dlane r_dl [NDIV+1][clpm_pkg::NLANE];
    clpm_pkg::t_side  r_sd [NSD];
    logic [clpm_pkg::NLANE-1:0] n5_shrt;
    logic [clpm_pkg::NLANE-1:0] n5_pre;
    logic [clpm_pkg::NLANE-1:0] n5_post;

    always_comb begin
        for (int l = 0; l < clpm_pkg::NLANE; l++) begin
            n5_shrt[l] = (r4_len2[l] == '0)
                         || (r4_len2[l] < {14'd0, r_min_len_sq, 16'd0});
            n5_pre[l]  = r4_dot[l] <= 0;
            n5_post[l] = r4_dot[l] >= $signed({1'b0, r4_len2[l]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < clpm_pkg::NLANE; l++) begin
                r_dl[0][l].rem  <= r4_dot[l][clpm_pkg::LW-1:0];
                r_dl[0][l].len2 <= r4_len2[l];
                r_dl[0][l].t    <= '0;
                r_dl[0][l].dx   <= r4_dx[l];
                r_dl[0][l].dy   <= r4_dy[l];
                r_dl[0][l].qx   <= r4_qx[l];
                r_dl[0][l].qy   <= r4_qy[l];
                r_dl[0][l].dfix <= (n5_shrt[l] || n5_pre[l]) ? r4_ds[l] : r4_de[l];
                r_dl[0][l].mid  <= !n5_shrt[l] && !n5_pre[l] && !n5_post[l];
            end
            r_sd[0].ang  <= r4_ang;
            r_sd[0].shrt <= |n5_shrt;
            for (int k = 1; k <= NDIV; k++) begin
                for (int l = 0; l < clpm_pkg::NLANE; l++) begin
                    r_dl[k][l] <= div_step(r_dl[k-1][l]);
                end
            end
            for (int k = 1; k < NSD; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // Closest point on the segment and its squared distance.
    logic signed [clpm_pkg::PW-1:0] r_m1_tx [clpm_pkg::NLANE];
    logic signed [clpm_pkg::PW-1:0] r_m1_ty [clpm_pkg::NLANE];
    logic signed [clpm_pkg::DW-1:0] r_m1_qx [clpm_pkg::NLANE];
    logic signed [clpm_pkg::DW-1:0] r_m1_qy [clpm_pkg::NLANE];
    logic [clpm_pkg::LW-1:0]        r_m1_dfix [clpm_pkg::NLANE];
    logic                           r_m1_mid  [clpm_pkg::NLANE];
    logic signed [clpm_pkg::EW-1:0] r_m2_ex [clpm_pkg::NLANE];
    logic signed [clpm_pkg::EW-1:0] r_m2_ey [clpm_pkg::NLANE];
    logic [clpm_pkg::LW-1:0]        r_m2_dfix [clpm_pkg::NLANE];
    logic                           r_m2_mid  [clpm_pkg::NLANE];
    logic [clpm_pkg::SQW-1:0]       r_m3_ex2 [clpm_pkg::NLANE];
    logic [clpm_pkg::SQW-1:0]       r_m3_ey2 [clpm_pkg::NLANE];
    logic [clpm_pkg::LW-1:0]        r_m3_dfix [clpm_pkg::NLANE];
    logic                           r_m3_mid  [clpm_pkg::NLANE];
    logic [clpm_pkg::QW-1:0]        r_m4_dq [clpm_pkg::NLANE];
    logic [clpm_pkg::QW-1:0]        r_m5_lo, r_m5_hi, r_m6_min;
    logic signed [clpm_pkg::PW-1:0] n2_rx [clpm_pkg::NLANE];
    logic signed [clpm_pkg::PW-1:0] n2_ry [clpm_pkg::NLANE];
    logic signed [2*clpm_pkg::EW-1:0] n3_ex2 [clpm_pkg::NLANE];
    logic signed [2*clpm_pkg::EW-1:0] n3_ey2 [clpm_pkg::NLANE];
    logic [clpm_pkg::LW-1:0]        n4_dist [clpm_pkg::NLANE];

    always_comb begin
        for (int l = 0; l < clpm_pkg::NLANE; l++) begin
            n2_rx[l]   = (r_m1_tx[l] + clpm_pkg::PW'(32768)) >>> 16;
            n2_ry[l]   = (r_m1_ty[l] + clpm_pkg::PW'(32768)) >>> 16;
            n3_ex2[l]  = (2*clpm_pkg::EW)'(r_m2_ex[l]) * (2*clpm_pkg::EW)'(r_m2_ex[l]);
            n3_ey2[l]  = (2*clpm_pkg::EW)'(r_m2_ey[l]) * (2*clpm_pkg::EW)'(r_m2_ey[l]);
            n4_dist[l] = r_m3_mid[l]
                         ? clpm_pkg::LW'(r_m3_ex2[l]) + clpm_pkg::LW'(r_m3_ey2[l])
                         : r_m3_dfix[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < clpm_pkg::NLANE; l++) begin
                r_m1_tx[l]   <= clpm_pkg::PW'($signed({1'b0, r_dl[NDIV][l].t}))
                                * clpm_pkg::PW'(r_dl[NDIV][l].dx);
                r_m1_ty[l]   <= clpm_pkg::PW'($signed({1'b0, r_dl[NDIV][l].t}))
                                * clpm_pkg::PW'(r_dl[NDIV][l].dy);
                r_m1_qx[l]   <= r_dl[NDIV][l].qx;
                r_m1_qy[l]   <= r_dl[NDIV][l].qy;
                r_m1_dfix[l] <= r_dl[NDIV][l].dfix;
                r_m1_mid[l]  <= r_dl[NDIV][l].mid;
                r_m2_ex[l]   <= clpm_pkg::EW'(r_m1_qx[l])
                                - clpm_pkg::EW'($signed(n2_rx[l][clpm_pkg::DW-1:0]));
                r_m2_ey[l]   <= clpm_pkg::EW'(r_m1_qy[l])
                                - clpm_pkg::EW'($signed(n2_ry[l][clpm_pkg::DW-1:0]));
                r_m2_dfix[l] <= r_m1_dfix[l];
                r_m2_mid[l]  <= r_m1_mid[l];
                r_m3_ex2[l]  <= n3_ex2[l][clpm_pkg::SQW-1:0];
                r_m3_ey2[l]  <= n3_ey2[l][clpm_pkg::SQW-1:0];
                r_m3_dfix[l] <= r_m2_dfix[l];
                r_m3_mid[l]  <= r_m2_mid[l];
                r_m4_dq[l]   <= n4_dist[l][clpm_pkg::LW-1:16];
            end
            r_m5_lo  <= (r_m4_dq[1] < r_m4_dq[0]) ? r_m4_dq[1] : r_m4_dq[0];
            r_m5_hi  <= (r_m4_dq[3] < r_m4_dq[2]) ? r_m4_dq[3] : r_m4_dq[2];
            r_m6_min <= (r_m5_hi < r_m5_lo) ? r_m5_hi : r_m5_lo;
        end
    end

    // Output word register.
    clpm_pkg::t_out_word r_out;
    logic                n_dst;

    assign n_dst = {2'd0, r_m6_min} < r_max_dist_sq;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.merge_ok      <= r_sd[NSD-1].ang && n_dst;
            r_out.angle_ok      <= r_sd[NSD-1].ang;
            r_out.distance_ok   <= n_dst;
            r_out.min_dist_sq   <= {2'd0, r_m6_min};
            r_out.short_segment <= r_sd[NSD-1].shrt;
        end
    end

    assign o_res.data = r_out;

endmodule

@@ design/clpm_checker.sv @@
// Port-level checker for the cluster pair merge test, bound to the top level.
// Depends on clpm_pkg and on cluster_pair_merge_test.
module clpm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input clpm_pkg::t_out_word i_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("output word changed while stalled");

    a_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.merge_ok
                        == (i_out_data.angle_ok && i_out_data.distance_ok))
        else $error("merge flag disagrees with the two tests");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.min_dist_sq[47:46] == 2'b00)
        else $error("distance beyond its possible range");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input held off with an empty output stage");

endmodule

bind cluster_pair_merge_test clpm_checker u_clpm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pair.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

@@ bench/cluster_pair_merge_checker.sv @@
// Checker for the cluster pair merge test: watches both channels and the register port,
// predicts each result word from the accepted pair word and compares it field by field.
// Depends on clpm_pkg and the channel interfaces in clpm_if.
module cluster_pair_merge_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clpm_in_if          pair,
    clpm_out_if         res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);

    logic [15:0] wire_scale, time_scale, max_angle_diff;
    logic [23:0] slope_scale;
    logic [31:0] min_len_sq;
    logic [47:0] max_dist_sq;
    clpm_pkg::t_out_word expected_q[$];

    function automatic logic [63:0] sq(input longint v);
        logic [63:0] m;
        m = v < 0 ? -v : v;
        return m * m;
    endfunction

    function automatic longint round16(input longint p);
        longint v;
        v = p + 32768;
        return v >>> 16;
    endfunction

    function automatic logic [63:0] point_to_segment(input longint px, input longint py,
            input longint sx, input longint sy, input longint ex, input longint ey,
            inout logic shrt);
        longint dx, dy, dot, cx, cy;
        logic [63:0] len2, r, t;
        logic [127:0] wide;
        dx = ex - sx;
        dy = ey - sy;
        len2 = sq(dx) + sq(dy);
        if (len2 == 0 || len2 < ({32'd0, min_len_sq} << 16)) begin
            shrt = 1'b1;
            return sq(px - sx) + sq(py - sy);
        end
        dot = (px - sx) * dx + (py - sy) * dy;
        if (dot <= 0) return sq(px - sx) + sq(py - sy);
        if (dot >= len2) return sq(px - ex) + sq(py - ey);
        r = dot;
        wide = {64'd0, r} << 16;
        wide = wide / {64'd0, len2};
        t = wide[63:0];
        cx = sx + round16(longint'(t) * dx);
        cy = sy + round16(longint'(t) * dy);
        return sq(px - cx) + sq(py - cy);
    endfunction

    function automatic clpm_pkg::t_out_word merge_verdict(input clpm_pkg::t_in_word w);
        clpm_pkg::t_out_word o;
        longint asw, ast, aew, aet, bsw, bst, bew, bet, d, cut, half;
        logic [63:0] m, v;
        logic shrt;
        asw = w.a_start_wire * wire_scale;
        ast = w.a_start_tick * time_scale;
        aew = w.a_end_wire * wire_scale;
        aet = w.a_end_tick * time_scale;
        bsw = w.b_start_wire * wire_scale;
        bst = w.b_start_tick * time_scale;
        bew = w.b_end_wire * wire_scale;
        bet = w.b_end_tick * time_scale;
        d = longint'(w.a_slope) * longint'(slope_scale)
            - longint'(w.b_slope) * longint'(slope_scale);
        half = longint'(180) << 24;
        cut = longint'(max_angle_diff) << 16;
        shrt = 1'b0;
        o.angle_ok = (d < 0 ? -d : d) < cut || ((d - half) < 0 ? half - d : d - half) < cut
            || ((d + half) < 0 ? -(d + half) : d + half) < cut;
        m = point_to_segment(asw, ast, bsw, bst, bew, bet, shrt) >> 16;
        v = point_to_segment(aew, aet, bsw, bst, bew, bet, shrt) >> 16;
        if (v < m) m = v;
        v = point_to_segment(bsw, bst, asw, ast, aew, aet, shrt) >> 16;
        if (v < m) m = v;
        v = point_to_segment(bew, bet, asw, ast, aew, aet, shrt) >> 16;
        if (v < m) m = v;
        if (m > 64'hFFFF_FFFF_FFFF) m = 64'hFFFF_FFFF_FFFF;
        o.min_dist_sq = m[47:0];
        o.distance_ok = m[47:0] < max_dist_sq;
        o.merge_ok = o.angle_ok && o.distance_ok;
        o.short_segment = shrt;
        return o;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_results = 0;
    end

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        clpm_pkg::t_out_word e;
        if (!i_rst_n) begin
            wire_scale <= 16'd19661;
            time_scale <= 16'd3604;
            slope_scale <= 24'd12015;
            min_len_sq <= 32'd198;
            max_angle_diff <= 16'd46080;
            max_dist_sq <= 48'hFFFF_FFFF_FFFF;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    clpm_pkg::REG_WIRE_SCALE:     wire_scale <= pwdata[15:0];
                    clpm_pkg::REG_TIME_SCALE:     time_scale <= pwdata[15:0];
                    clpm_pkg::REG_SLOPE_SCALE:    slope_scale <= pwdata[23:0];
                    clpm_pkg::REG_MIN_LEN_SQ:     min_len_sq <= pwdata[31:0];
                    clpm_pkg::REG_MAX_ANGLE_DIFF: max_angle_diff <= pwdata[15:0];
                    clpm_pkg::REG_MAX_DIST_SQ:    max_dist_sq <= pwdata[47:0];
                    default: ;
                endcase
            end
            if (pair.valid && pair.ready)
                expected_q.insert(expected_q.size(), merge_verdict(pair.data));
            if (res.valid && res.ready) begin
                o_results++;
                if (expected_q.size() == 0) begin
                    report("unexpected word", res.data, 0);
                end else begin
                    e = expected_q.pop_front();
                    if (res.data.merge_ok !== e.merge_ok)
                        report("merge_ok", res.data.merge_ok, e.merge_ok);
                    if (res.data.angle_ok !== e.angle_ok)
                        report("angle_ok", res.data.angle_ok, e.angle_ok);
                    if (res.data.distance_ok !== e.distance_ok)
                        report("distance_ok", res.data.distance_ok, e.distance_ok);
                    if (res.data.min_dist_sq !== e.min_dist_sq)
                        report("min_dist_sq", res.data.min_dist_sq, e.min_dist_sq);
                    if (res.data.short_segment !== e.short_segment)
                        report("short_segment", res.data.short_segment, e.short_segment);
                end
            end
        end
    end
endmodule

@@ bench/cluster_pair_merge_test_test.sv @@
// Testbench top for the cluster pair merge test: drives pair words and register writes
// under several idling phases and gives the verdict. Depends on clpm_pkg, clpm_if,
// cluster_pair_merge_checker and the block itself.
module cluster_pair_merge_test_test;

    localparam int LATENCY = 28;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    int          errors, pending, results, cycles, sent;
    int          send_idle, recv_stall;

    clpm_in_if  pair_ch();
    clpm_out_if res_ch();

    initial begin
        pair_ch.valid = 1'b0;
        pair_ch.data = '0;
        res_ch.ready = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    cluster_pair_merge_test dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pair(pair_ch), .o_res(res_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    cluster_pair_merge_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .pair(pair_ch), .res(res_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .o_errors(errors), .o_pending(pending),
        .o_results(results)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        res_ch.ready <= ($urandom_range(99) >= recv_stall);
        if (cycles > 2000000) begin
            $display("cluster_pair_merge_test_test: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 3'b000}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain;
        pair_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_pair(input clpm_pkg::t_in_word w);
        if ($urandom_range(99) < send_idle) begin
            pair_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
        pair_ch.valid <= 1'b1;
        pair_ch.data <= w;
        @(posedge i_clk);
        while (!pair_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    function automatic clpm_pkg::t_in_word random_pair(input int mode);
        clpm_pkg::t_in_word w;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom};
        if (mode == 1) begin
            w.a_start_wire = $urandom_range(300, 200); w.a_end_wire = $urandom_range(300, 200);
            w.b_start_wire = $urandom_range(300, 200); w.b_end_wire = $urandom_range(300, 200);
            w.a_start_tick = $urandom_range(2000, 1000);
            w.a_end_tick = $urandom_range(2000, 1000);
            w.b_start_tick = $urandom_range(2000, 1000);
            w.b_end_tick = $urandom_range(2000, 1000);
            w.b_slope = w.a_slope + $signed(16'($urandom_range(400))) - 16'sd200;
        end else if (mode == 2) begin
            w.a_end_wire = w.a_start_wire + $urandom_range(1);
            w.a_end_tick = w.a_start_tick + $urandom_range(2);
            w.b_slope = w.a_slope;
        end
        return w;
    endfunction

    task automatic directed_pairs;
        clpm_pkg::t_in_word w;
        w = '0; send_pair(w);
        w = '1; send_pair(w);
        w = '0; w.a_slope = 16'sh7FFF; w.b_slope = -16'sh8000;
        w.a_end_wire = 13'h1FFF; w.b_start_tick = 14'h3FFF; send_pair(w);
        w = '0; w.a_end_wire = 100; w.a_end_tick = 100;
        w.b_start_wire = 150; w.b_start_tick = 50; w.b_end_wire = 150; w.b_end_tick = 50;
        send_pair(w);
        w.b_start_wire = 13'h1FFF; w.b_end_wire = 13'h1FFF; send_pair(w);
        w.b_start_wire = 0; w.b_start_tick = 14'h3FFF; w.b_end_wire = 0;
        w.b_end_tick = 14'h3FFF; send_pair(w);
        w = '1; w.a_start_wire = 0; w.a_start_tick = 0; w.b_start_wire = 0;
        w.b_end_tick = 0; send_pair(w);
        w = '0; w.a_slope = 16'sd1000; w.b_slope = -16'sd1000; send_pair(w);
        for (int k = 0; k < 8; k++) send_pair(random_pair(k % 3));
    endtask

    task automatic random_phase(input int n, input int idle, input int stall);
        send_idle = idle;
        recv_stall = stall;
        for (int k = 0; k < n; k++) begin
            send_pair(random_pair($urandom_range(3) == 0 ? 0 : ($urandom_range(1) + 1)));
            if (k == n / 2) drain();
        end
        drain();
    endtask

    initial begin
        cycles = 0; sent = 0; send_idle = 0; recv_stall = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_pairs();
        drain();
        random_phase(300, 0, 0);
        write_reg(clpm_pkg::REG_WIRE_SCALE, 64'd65535);
        write_reg(clpm_pkg::REG_TIME_SCALE, 64'd0);
        write_reg(clpm_pkg::REG_SLOPE_SCALE, 64'hFFFFFF);
        write_reg(clpm_pkg::REG_MIN_LEN_SQ, 64'hFFFF_FFFF);
        write_reg(clpm_pkg::REG_MAX_ANGLE_DIFF, 64'd0);
        write_reg(clpm_pkg::REG_MAX_DIST_SQ, 64'd0);
        directed_pairs();
        random_phase(300, 76, 0);
        write_reg(clpm_pkg::REG_WIRE_SCALE, 64'd0);
        write_reg(clpm_pkg::REG_TIME_SCALE, 64'd65535);
        write_reg(clpm_pkg::REG_SLOPE_SCALE, 64'd0);
        write_reg(clpm_pkg::REG_MIN_LEN_SQ, 64'd0);
        write_reg(clpm_pkg::REG_MAX_ANGLE_DIFF, 64'd65535);
        write_reg(clpm_pkg::REG_MAX_DIST_SQ, 64'hFFFF_FFFF_FFFF);
        random_phase(300, 0, 76);
        write_reg(clpm_pkg::REG_WIRE_SCALE, $urandom_range(65535));
        write_reg(clpm_pkg::REG_TIME_SCALE, $urandom_range(65535));
        write_reg(clpm_pkg::REG_SLOPE_SCALE, $urandom_range(24'hFFFFFF));
        write_reg(clpm_pkg::REG_MIN_LEN_SQ, $urandom_range(4000));
        write_reg(clpm_pkg::REG_MAX_ANGLE_DIFF, $urandom_range(3000));
        write_reg(clpm_pkg::REG_MAX_DIST_SQ, {16'd0, $urandom});
        random_phase(350, 22, 22);
        write_reg(clpm_pkg::REG_WIRE_SCALE, 64'd19661);
        write_reg(clpm_pkg::REG_TIME_SCALE, 64'd3604);
        write_reg(clpm_pkg::REG_SLOPE_SCALE, 64'd12015);
        write_reg(clpm_pkg::REG_MIN_LEN_SQ, 64'd198);
        write_reg(clpm_pkg::REG_MAX_ANGLE_DIFF, 64'd5000);
        write_reg(clpm_pkg::REG_MAX_DIST_SQ, 64'd50000);
        random_phase(400, $urandom_range(1) * 50, $urandom_range(1) * 50);
        $display("Sent %0d pair words under five register settings and four idling phases;",
                 sent);
        $display("checked %0d result words against the prediction.", results);
        if (errors == 0) begin
            $display("cluster_pair_merge_test_test: done, clean");
        end else begin
            $display("cluster_pair_merge_test_test: done, errors");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
design/clpm_pkg.sv
design/clpm_if.sv
design/cluster_pair_merge_test.sv
design/clpm_checker.sv
bench/cluster_pair_merge_checker.sv
bench/cluster_pair_merge_test_test.sv
